FILE: hw/rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// shared types and constants of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_DIGITS  = 4'd1,
        PH_REST    = 4'd2,
        PH_SIZE_CR = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_TRAILER = 4'd7,
        PH_TR_CR   = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERROR   = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2,
        ST_AFTER = 2'd3
    } t_status;

    // classified input byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       start_new;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
    } t_item;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        t_status    status;
        logic [31:0] body_length;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/chd_front.sv
// ----------------------------------------------------------------------------
// chd_front
// byte classifier: hex digit value, blank, cr and lf flags
// ----------------------------------------------------------------------------
`default_nettype none

module chd_front (
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_start_new,
    output chd_pkg::t_item     o_item
);

    always_comb begin
        o_item           = '0;
        o_item.data      = i_data_byte;
        o_item.start_new = i_start_new;
        o_item.is_blank  = (i_data_byte == chd_pkg::CHR_SPACE) ||
                           (i_data_byte == chd_pkg::CHR_TAB);
        o_item.is_cr     = (i_data_byte == chd_pkg::CHR_CR);
        o_item.is_lf     = (i_data_byte == chd_pkg::CHR_LF);
        if (i_data_byte inside {[8'h30:8'h39]}) begin
            o_item.is_hex  = 1'b1;
            o_item.hex_val = i_data_byte[3:0];
        end else if (i_data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            // a..f and A..F share the low bits 1..6
            o_item.is_hex  = 1'b1;
            o_item.hex_val = i_data_byte[3:0] + 4'd9;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/chd_queue.sv
// ----------------------------------------------------------------------------
// chd_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module chd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire chd_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output chd_pkg::t_item      o_item
);

    chd_pkg::t_item                    r_mem [chd_pkg::QUEUE_DEPTH];
    logic [chd_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [chd_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [chd_pkg::QUEUE_CNT_W-1:0]   r_count, n_count;
    logic                              push_ok, pop_ok;

    assign o_full  = (r_count == chd_pkg::QUEUE_CNT_W'(chd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/chd_back.sv
// ----------------------------------------------------------------------------
// chd_back
// per-byte decode state machine with output register
// ----------------------------------------------------------------------------
`default_nettype none

module chd_back #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire chd_pkg::t_item i_item,
    output logic                o_pop,
    output chd_pkg::t_result    o_result,
    output logic                o_valid,
    input  wire logic           i_ready
);

    chd_pkg::t_phase        r_phase, n_phase, cur_phase;
    logic [SIZE_BITS-1:0]   r_accum, n_accum, cur_accum, accum_add;
    logic [SIZE_BITS-1:0]   r_left, n_left, cur_left;
    logic [31:0]            r_total, n_total, cur_total;
    logic                   r_empty, n_empty, cur_empty;
    logic                   r_out_valid;
    chd_pkg::t_result       r_result, n_result;

    assign o_pop    = !i_empty && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // start_new restarts from the reset state before this byte
    always_comb begin
        cur_phase = i_item.start_new ? chd_pkg::PH_LEAD : r_phase;
        cur_accum = i_item.start_new ? '0 : r_accum;
        cur_left  = i_item.start_new ? '0 : r_left;
        cur_total = i_item.start_new ? '0 : r_total;
        cur_empty = i_item.start_new ? 1'b1 : r_empty;
    end

    // saturating hex shift-in
    assign accum_add = (|cur_accum[SIZE_BITS-1 -: 4]) ? '1 :
                       {cur_accum[SIZE_BITS-5:0], i_item.hex_val};

    // next phase
    always_comb begin
        n_phase = cur_phase;
        case (cur_phase)
            chd_pkg::PH_LEAD: begin
                if (i_item.is_blank) n_phase = chd_pkg::PH_LEAD;
                else if (i_item.is_hex) n_phase = chd_pkg::PH_DIGITS;
                else if (i_item.is_cr) n_phase = chd_pkg::PH_SIZE_CR;
                else n_phase = chd_pkg::PH_REST;
            end
            chd_pkg::PH_DIGITS: begin
                if (i_item.is_hex) n_phase = chd_pkg::PH_DIGITS;
                else if (i_item.is_cr) n_phase = chd_pkg::PH_SIZE_CR;
                else n_phase = chd_pkg::PH_REST;
            end
            chd_pkg::PH_REST: begin
                if (i_item.is_cr) n_phase = chd_pkg::PH_SIZE_CR;
            end
            chd_pkg::PH_SIZE_CR: begin
                if (i_item.is_lf) begin
                    n_phase = (cur_accum == '0) ? chd_pkg::PH_TRAILER : chd_pkg::PH_DATA;
                end else if (!i_item.is_cr) begin
                    n_phase = chd_pkg::PH_REST;
                end
            end
            chd_pkg::PH_DATA: begin
                if (cur_left == SIZE_BITS'(1)) n_phase = chd_pkg::PH_DATA_CR;
            end
            chd_pkg::PH_DATA_CR: begin
                n_phase = i_item.is_cr ? chd_pkg::PH_DATA_LF : chd_pkg::PH_ERROR;
            end
            chd_pkg::PH_DATA_LF: begin
                n_phase = i_item.is_lf ? chd_pkg::PH_LEAD : chd_pkg::PH_ERROR;
            end
            chd_pkg::PH_TRAILER: begin
                if (i_item.is_cr) n_phase = chd_pkg::PH_TR_CR;
            end
            chd_pkg::PH_TR_CR: begin
                if (i_item.is_lf) begin
                    n_phase = cur_empty ? chd_pkg::PH_DONE : chd_pkg::PH_TRAILER;
                end else if (!i_item.is_cr) begin
                    n_phase = chd_pkg::PH_TRAILER;
                end
            end
            chd_pkg::PH_DONE: n_phase = chd_pkg::PH_DONE;
            default:          n_phase = chd_pkg::PH_ERROR;
        endcase
    end

    // datapath and result
    always_comb begin
        n_accum  = cur_accum;
        n_left   = cur_left;
        n_total  = cur_total;
        n_empty  = cur_empty;
        n_result = '0;
        n_result.status = chd_pkg::ST_BUSY;
        case (cur_phase)
            chd_pkg::PH_LEAD, chd_pkg::PH_DIGITS: begin
                if (i_item.is_hex) n_accum = accum_add;
            end
            chd_pkg::PH_REST: begin
                n_accum = cur_accum;
            end
            chd_pkg::PH_SIZE_CR: begin
                if (i_item.is_lf) begin
                    if (cur_accum == '0) n_empty = 1'b1;
                    else n_left = cur_accum;
                end
            end
            chd_pkg::PH_DATA: begin
                n_result.body_valid = 1'b1;
                n_result.body_byte  = i_item.data;
                if (cur_total != 32'hffff_ffff) n_total = cur_total + 32'd1;
                n_left = cur_left - SIZE_BITS'(1);
            end
            chd_pkg::PH_DATA_CR: begin
                if (!i_item.is_cr) n_result.status = chd_pkg::ST_ERROR;
            end
            chd_pkg::PH_DATA_LF: begin
                if (i_item.is_lf) n_accum = '0;
                else n_result.status = chd_pkg::ST_ERROR;
            end
            chd_pkg::PH_TRAILER: begin
                if (!i_item.is_cr) n_empty = 1'b0;
            end
            chd_pkg::PH_TR_CR: begin
                if (i_item.is_lf) begin
                    if (cur_empty) n_result.status = chd_pkg::ST_DONE;
                    else n_empty = 1'b1;
                end else begin
                    n_empty = 1'b0;
                end
            end
            chd_pkg::PH_DONE: n_result.status = chd_pkg::ST_AFTER;
            default:          n_result.status = chd_pkg::ST_ERROR;
        endcase
        n_result.body_length = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= chd_pkg::PH_LEAD;
            r_accum     <= '0;
            r_left      <= '0;
            r_total     <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_accum <= n_accum;
                r_left  <= n_left;
                r_total <= n_total;
                r_empty <= n_empty;
            end
            if (o_pop) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_result <= n_result;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// chunked transfer body decoder: one raw byte in, one result out per byte
// ----------------------------------------------------------------------------
// each byte is written into the queue, then its result is registered in the back end
// throughput: one byte per cycle while the result channel does not stall, set by the phase update in the back end
// the 4-entry queue lets input and output stall independently
// reset clears the phase, size, counters, the queue and the valid flag of the output register
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_new,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_body_byte,
    output logic             o_body_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_body_length
);

    chd_pkg::t_item   front_item;
    chd_pkg::t_item   queue_item;
    chd_pkg::t_result result;
    logic             queue_full;
    logic             queue_empty;
    logic             back_pop;

    // front: classify each byte as it is taken in
    chd_front u_front (
        .i_data_byte (i_data_byte),
        .i_start_new (i_start_new),
        .o_item      (front_item)
    );

    // input transaction accepted whenever the queue has room
    assign o_ready = !queue_full;

    chd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    // back: size line, payload, trailer tracking and output register
    chd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (queue_empty),
        .i_item   (queue_item),
        .o_pop    (back_pop),
        .o_result (result),
        .o_valid  (o_valid),
        .i_ready  (i_ready)
    );

    // result fields as separate ports
    assign o_body_byte   = result.body_byte;
    assign o_body_valid  = result.body_valid;
    assign o_status      = result.status;
    assign o_body_length = result.body_length;

endmodule

`default_nettype wire

FILE: tb/http_chunked_body_decoder_test.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test
// self-checking bench for the chunked body decoder: a directed opening covers
// blanks, extensions, lone CR/LF, trailers, completion, sticky errors and size
// saturation, then random chunked bodies (mostly well formed, some broken or
// pure noise) run under several idle/stall mixes; every result transaction is
// checked against an in-bench decoder model
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_test;

    localparam int SIZE_W       = 32;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // characters the stimulus and the decoder model need beyond the package set
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_F = 8'h66;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_F = 8'h46;
    localparam logic [7:0] CHR_SEMI    = 8'h3b;

    // one raw byte as offered on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_raw_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_start_new = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_body_byte;
    logic        o_body_valid;
    logic [1:0]  o_status;
    logic [31:0] o_body_length;

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_start_new  (i_start_new),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_body_byte  (o_body_byte),
        .o_body_valid (o_body_valid),
        .o_status     (o_status),
        .o_body_length(o_body_length)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_raw_byte        bytes_to_send[$];     // filled by the stimulus, drained by the driver
    chd_pkg::t_result decoded_expected[$];  // predicted result per accepted byte
    int unsigned      bytes_queued = 0;
    logic             start_pending = 1'b0; // next queued byte carries start_new
    logic             in_taken = 1'b0;      // input transaction at the last rising edge
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      hold_request = 0;     // long receiver hold-off, picked up by the receiver
    int unsigned      hold_left = 0;
    int unsigned      cycle_count = 0;
    int unsigned      mismatch_count = 0;
    int unsigned      result_count = 0;

    // decoder model state
    chd_pkg::t_phase dec_phase;
    logic [63:0]     dec_size;
    logic [63:0]     dec_left;
    logic [31:0]     dec_total;
    logic            dec_line_empty;

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic void clear_decoder();
        dec_phase      = chd_pkg::PH_LEAD;
        dec_size       = '0;
        dec_left       = '0;
        dec_total      = '0;
        dec_line_empty = 1'b1;
    endfunction

    // shift in one hex digit, saturating at the largest size
    function automatic void push_digit(input logic [3:0] d);
        logic [63:0] size_max;
        size_max = {64{1'b1}} >> (64 - SIZE_W);
        if (dec_size > (size_max >> 4)) begin
            dec_size = size_max;
        end else begin
            dec_size = (dec_size << 4) | 64'(d);
            if (dec_size > size_max) dec_size = size_max;
        end
    endfunction

    // advance the model by one raw byte and return the result it must produce
    function automatic chd_pkg::t_result decode_step(input t_raw_byte rb);
        chd_pkg::t_result r;
        logic [7:0]       b;
        logic             is_hex;
        logic [3:0]       hv;
        logic             payload;
        chd_pkg::t_status st;
        b       = rb.data;
        payload = 1'b0;
        st      = chd_pkg::ST_BUSY;
        if (rb.start) clear_decoder();

        is_hex = 1'b1;
        hv     = 4'd0;
        if (b >= CHR_ZERO && b <= CHR_NINE) hv = 4'(b - CHR_ZERO);
        else if (b >= CHR_LOWER_A && b <= CHR_LOWER_F) hv = 4'(b - CHR_LOWER_A + 8'd10);
        else if (b >= CHR_UPPER_A && b <= CHR_UPPER_F) hv = 4'(b - CHR_UPPER_A + 8'd10);
        else is_hex = 1'b0;

        case (dec_phase)
            chd_pkg::PH_LEAD: begin
                // only space and tab are skipped as leading blanks
                if (b != chd_pkg::CHR_SPACE && b != chd_pkg::CHR_TAB) begin
                    if (is_hex) begin
                        push_digit(hv);
                        dec_phase = chd_pkg::PH_DIGITS;
                    end else if (b == chd_pkg::CHR_CR) begin
                        dec_phase = chd_pkg::PH_SIZE_CR;
                    end else begin
                        dec_phase = chd_pkg::PH_REST;
                    end
                end
            end
            chd_pkg::PH_DIGITS: begin
                if (is_hex) push_digit(hv);
                else if (b == chd_pkg::CHR_CR) dec_phase = chd_pkg::PH_SIZE_CR;
                else dec_phase = chd_pkg::PH_REST;
            end
            chd_pkg::PH_REST: begin
                if (b == chd_pkg::CHR_CR) dec_phase = chd_pkg::PH_SIZE_CR;
            end
            chd_pkg::PH_SIZE_CR: begin
                if (b == chd_pkg::CHR_LF) begin
                    // a line with no digits means size zero: trailer follows
                    if (dec_size == 0) begin
                        dec_phase      = chd_pkg::PH_TRAILER;
                        dec_line_empty = 1'b1;
                    end else begin
                        dec_left  = dec_size;
                        dec_phase = chd_pkg::PH_DATA;
                    end
                end else if (b != chd_pkg::CHR_CR) begin
                    dec_phase = chd_pkg::PH_REST;
                end
            end
            chd_pkg::PH_DATA: begin
                payload = 1'b1;
                if (dec_total != 32'hffff_ffff) dec_total++;
                dec_left--;
                if (dec_left == 0) dec_phase = chd_pkg::PH_DATA_CR;
            end
            chd_pkg::PH_DATA_CR: begin
                if (b == chd_pkg::CHR_CR) begin
                    dec_phase = chd_pkg::PH_DATA_LF;
                end else begin
                    dec_phase = chd_pkg::PH_ERROR;
                    st        = chd_pkg::ST_ERROR;
                end
            end
            chd_pkg::PH_DATA_LF: begin
                if (b == chd_pkg::CHR_LF) begin
                    dec_phase = chd_pkg::PH_LEAD;
                    dec_size  = '0;
                end else begin
                    dec_phase = chd_pkg::PH_ERROR;
                    st        = chd_pkg::ST_ERROR;
                end
            end
            chd_pkg::PH_TRAILER: begin
                if (b == chd_pkg::CHR_CR) dec_phase = chd_pkg::PH_TR_CR;
                else dec_line_empty = 1'b0;
            end
            chd_pkg::PH_TR_CR: begin
                if (b == chd_pkg::CHR_LF) begin
                    if (dec_line_empty) begin
                        dec_phase = chd_pkg::PH_DONE;
                        st        = chd_pkg::ST_DONE;
                    end else begin
                        dec_phase      = chd_pkg::PH_TRAILER;
                        dec_line_empty = 1'b1;
                    end
                end else begin
                    // a lone CR in a trailer line is content
                    dec_line_empty = 1'b0;
                    if (b != chd_pkg::CHR_CR) dec_phase = chd_pkg::PH_TRAILER;
                end
            end
            chd_pkg::PH_DONE: begin
                st = chd_pkg::ST_AFTER;
            end
            default: begin
                // error is sticky until start_new
                dec_phase = chd_pkg::PH_ERROR;
                st        = chd_pkg::ST_ERROR;
            end
        endcase

        r.body_byte   = payload ? b : 8'h00;
        r.body_valid  = payload;
        r.status      = st;
        r.body_length = dec_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] d);
        t_raw_byte rb;
        rb.data       = d;
        rb.start      = start_pending;
        start_pending = 1'b0;
        bytes_to_send.push_back(rb);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    // size line: optional blanks, hex digits in mixed case, maybe an extension
    task automatic queue_size_line(input int unsigned size);
        int         nd;
        int         lead;
        logic [3:0] v;
        repeat ($urandom_range(2)) begin
            queue_byte($urandom_range(1) ? chd_pkg::CHR_SPACE : chd_pkg::CHR_TAB);
        end
        nd = 1;
        while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
        if (size == 0 && $urandom_range(3) == 0) nd = 0;
        lead = (nd != 0 && $urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead) queue_byte(CHR_ZERO);
        for (int i = nd - 1; i >= 0; i--) begin
            v = 4'(size >> (4 * i));
            if (v < 10) queue_byte(CHR_ZERO + 8'(v));
            else if ($urandom_range(1)) queue_byte(CHR_UPPER_A + 8'(v) - 8'd10);
            else queue_byte(CHR_LOWER_A + 8'(v) - 8'd10);
        end
        if ($urandom_range(3) == 0) begin
            queue_byte(CHR_SEMI);
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(9))
                    0: queue_byte(chd_pkg::CHR_LF);
                    1: begin
                        queue_byte(chd_pkg::CHR_CR);
                        queue_byte(8'($urandom_range(33, 126)));
                    end
                    default: queue_byte(8'($urandom_range(33, 126)));
                endcase
            end
        end
        queue_byte(chd_pkg::CHR_CR);
        queue_byte(chd_pkg::CHR_LF);
    endtask

    // mostly well-formed bodies with random content, some broken, some noise
    task automatic queue_random_bodies(input int unsigned n);
        int unsigned target;
        int unsigned chunks;
        int unsigned size;
        logic        broken;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            start_pending = ($urandom_range(9) != 0);
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(4, 16)) begin
                    case ($urandom_range(4))
                        0: queue_byte(chd_pkg::CHR_CR);
                        1: queue_byte(chd_pkg::CHR_LF);
                        default: queue_byte(8'($urandom_range(255)));
                    endcase
                end
            end else begin
                broken = 1'b0;
                chunks = $urandom_range(3);
                for (int c = 0; c < chunks && !broken; c++) begin
                    size = ($urandom_range(9) == 0) ? $urandom_range(1, 60)
                                                    : $urandom_range(1, 12);
                    queue_size_line(size);
                    repeat (size) queue_byte(8'($urandom_range(255)));
                    if ($urandom_range(15) == 0) begin
                        // payload not followed by CRLF
                        broken = 1'b1;
                        if ($urandom_range(1)) begin
                            queue_byte(8'($urandom_range(14, 255)));
                        end else begin
                            queue_byte(chd_pkg::CHR_CR);
                            queue_byte(8'($urandom_range(11, 255)));
                        end
                    end else begin
                        queue_byte(chd_pkg::CHR_CR);
                        queue_byte(chd_pkg::CHR_LF);
                    end
                end
                if (broken) begin
                    repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
                end else begin
                    queue_size_line(0);
                    repeat ($urandom_range(2)) begin
                        repeat ($urandom_range(1, 10)) begin
                            if ($urandom_range(7) == 0) queue_byte(chd_pkg::CHR_LF);
                            else queue_byte(8'($urandom_range(32, 126)));
                        end
                        queue_byte(chd_pkg::CHR_CR);
                        queue_byte(chd_pkg::CHR_LF);
                    end
                    queue_byte(chd_pkg::CHR_CR);
                    queue_byte(chd_pkg::CHR_LF);
                    // bytes after completion
                    repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
                end
            end
        end
    endtask

    // sender pauses until every queued byte went in and every result came out;
    // checked just after the falling edge so the driver's update has settled
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (bytes_to_send.size() != 0 || i_valid || decoded_expected.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued bytes at the falling edge, holds until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_raw_byte rb;
        logic      offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            offer = bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
                rb = bytes_to_send.pop_front();
                i_data_byte <= rb.data;
                i_start_new <= rb.start;
            end
            i_valid <= offer;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each input transaction, checks each result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_raw_byte        rb;
        chd_pkg::t_result got;
        chd_pkg::t_result want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end else begin
                in_taken = i_valid && o_ready;
                if (in_taken) begin
                    rb.data  = i_data_byte;
                    rb.start = i_start_new;
                    decoded_expected.push_back(decode_step(rb));
                end
                if (o_valid && i_ready) begin
                    got.body_byte   = o_body_byte;
                    got.body_valid  = o_body_valid;
                    got.status      = chd_pkg::t_status'(o_status);
                    got.body_length = o_body_length;
                    if (decoded_expected.size() == 0) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"result %0d unexpected: byte=%02h valid=%0b ",
                                      "status=%0d len=%0d"},
                                     result_count, got.body_byte, got.body_valid,
                                     got.status, got.body_length);
                    end else begin
                        want = decoded_expected.pop_front();
                        if (got !== want) begin
                            mismatch_count++;
                            if (mismatch_count <= REPORT_MAX)
                                $display({"result %0d: expected byte=%02h valid=%0b status=%0d ",
                                          "len=%0d, got byte=%02h valid=%0b status=%0d len=%0d"},
                                         result_count, want.body_byte, want.body_valid,
                                         want.status, want.body_length, got.body_byte,
                                         got.body_valid, got.status, got.body_length);
                        end
                    end
                    result_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_decoder();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening, no idling
        // blanks, an extension and a one-byte chunk of 0xff
        start_pending = 1'b1;
        queue_text(" \t1;x\r\n");
        queue_byte(8'hff);
        queue_text("\r\n");
        // zero size line with a lone LF and a doubled CR
        queue_text("0\n\r\r\n");
        // trailer lines holding a lone CR and a lone LF, then the empty line
        queue_text("\r\r\n\n\r\n\r\n");
        // a byte after completion
        queue_byte(8'h00);
        // payload not followed by CRLF, then the error must stick
        start_pending = 1'b1;
        queue_text("1\r\n");
        queue_byte(8'h00);
        queue_text("xy");
        // oversized size saturates; one payload byte then restart
        start_pending = 1'b1;
        queue_text("fffffffff\r\n");
        queue_byte(8'h5a);
        // size line with no digits: straight into the trailer
        start_pending = 1'b1;
        queue_text("\r\n\r\n");
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_request = 300;
        queue_random_bodies(100);
        wait_drained();

        send_idle_pct  = 88;
        recv_stall_pct = 0;
        queue_random_bodies(200);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 88;
        queue_random_bodies(200);
        wait_drained();

        send_idle_pct  = 7;
        recv_stall_pct = 7;
        queue_random_bodies(200);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_bodies(100);
        wait_drained();

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        mismatch_count += decoded_expected.size();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
